### rtl/core/fpdk_pkg.sv
// ----------------------------------------------------------------------------
// fpdk_pkg
// Types and constants of the four-point delta kernel weight unit.
// ----------------------------------------------------------------------------
package fpdk_pkg;

  localparam int AXES   = 2;
  localparam int ROOT_W = 32;

  // pipeline stage positions
  localparam int ST_DIFF = 0;
  localparam int ST_R    = 1;
  localparam int ST_U    = 2;
  localparam int ST_ARG  = 3;
  localparam int ST_PHI  = ST_ARG + ROOT_W + 1;
  localparam int ST_FACT = ST_PHI + 1;
  localparam int ST_PART = ST_FACT + 1;
  localparam int ST_MID  = ST_PART + 1;
  localparam int ST_SUM  = ST_MID + 1;
  localparam int ST_OUT  = ST_SUM + 1;
  localparam int STAGES  = ST_OUT + 1;

  localparam logic [30:0] SPACING_RESET = 31'd6553600;
  localparam logic [35:0] WEIGHT_MAX    = 36'hF_FFFF_FFFF;
  localparam logic [63:0] ONE_Q32       = 64'h0000_0001_0000_0000;
  localparam logic [63:0] TWO_Q32       = 64'h0000_0002_0000_0000;
  localparam logic [32:0] ONE_Q32_N     = 33'h1_0000_0000;
  localparam logic [63:0] ARG_BASE      = 64'h4000_0000_0000_0000;
  localparam logic [35:0] THREE_Q32     = 36'h3_0000_0000;
  localparam logic [35:0] PHI_ROUND     = 36'd4;
  localparam logic [31:0] PHI_MAX       = 32'h8000_0000;

  typedef enum logic {
    REG_INV_SPACING_X = 1'b0,
    REG_INV_SPACING_Y = 1'b1
  } reg_index_t;

  // one axis inside the square-root pipeline
  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] root;
    logic [32:0] u;
    logic        near;
    logic        in_range;
  } root_lane_t;

endpackage

### rtl/core/four_point_delta_kernel_weight_unit.sv
// ----------------------------------------------------------------------------
// four_point_delta_kernel_weight_unit
// Two-dimensional four-point discrete delta weight of a cloud/grid point pair.
// ----------------------------------------------------------------------------
// Takes one cloud/grid point pair per transfer (x and y in signed Q16.16) and
// returns phi(rx) * phi(ry) * inv_spacing_x * inv_spacing_y in unsigned
// Q20.16, saturated at 2^36-1, plus a flag that is high when both scaled
// distances are at most two. phi is the four-point kernel, evaluated exactly
// in fixed point with a floor square root and round-half-up steps. The unit
// is a 42-stage pipeline: it sustains one pair per clock while the output
// is not stalled. The depth is set by the square-root pipeline, which
// resolves one root bit per stage over 32 stages. A stall at the output
// freezes the whole pipeline; a one entry skid register at the input still
// takes one more transfer while a finished result waits. Spacing registers
// may only be written while the unit holds no items.
module four_point_delta_kernel_weight_unit
  import fpdk_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // configuration write port
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [30:0]  cfg_data,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // cloud_x, cloud_y, grid_x, grid_y
  // output stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata,   // kernel_weight, 4 zero bits
  output logic         m_tuser    // in_support
);

  // spacing registers, index 0 is x
  logic [30:0] inv_spacing [AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_spacing[0] <= SPACING_RESET;
      inv_spacing[1] <= SPACING_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_INV_SPACING_X: inv_spacing[0] <= cfg_data;
        REG_INV_SPACING_Y: inv_spacing[1] <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: the whole pipeline moves unless the output is stalled
  logic              en;
  logic [STAGES-1:0] vld;

  assign en = m_tready || !vld[ST_OUT];

  // input skid register
  logic         skid_full;
  logic [127:0] skid_data;
  logic         in_valid;
  logic [127:0] in_data;

  assign s_tready = !skid_full;
  assign in_valid = skid_full || s_tvalid;
  assign in_data  = skid_full ? skid_data : s_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (en) begin
        skid_full <= 1'b0;
      end
    end else if (s_tvalid && !en) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full && s_tvalid && !en) begin
      skid_data <= s_tdata;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  // stage registers
  logic [32:0]  ad_q     [AXES];
  logic [63:0]  r_q      [AXES];
  logic [32:0]  u_q      [AXES];
  logic [31:0]  ua_q     [AXES];
  logic [31:0]  ub_q     [AXES];
  logic         near_q   [AXES];
  logic         inside_q [AXES];
  root_lane_t   rl       [ROOT_W+1][AXES];
  logic [31:0]  phi_q    [AXES];
  logic [62:0]  fac_q    [AXES];
  logic         sup_phi, sup_fact, sup_part, sup_mid, sup_sum, sup_out;
  logic [63:0]  p00_q;
  logic [62:0]  p01_q, p10_q;
  logic [61:0]  p11_q;
  logic [63:0]  p00_m;
  logic [61:0]  p11_m;
  logic [63:0]  mid_q;
  logic [47:0]  sum_hi_q;
  logic [35:0]  weight_q;

  // per-axis combinational work
  logic [31:0]  in_cloud [AXES];
  logic [31:0]  in_grid  [AXES];
  logic [32:0]  diff_c   [AXES];
  logic [32:0]  mag_c    [AXES];
  logic [63:0]  r_c      [AXES];
  logic         near_c   [AXES];
  logic         inside_c [AXES];
  logic [32:0]  u_c      [AXES];
  logic [32:0]  ub_c     [AXES];
  logic [63:0]  arg_c    [AXES];
  logic [32:0]  sq_c     [AXES];
  logic [35:0]  num_c    [AXES];
  logic [35:0]  rnd_c    [AXES];
  logic [31:0]  phi_c    [AXES];
  logic [62:0]  fac_c    [AXES];

  assign in_cloud[0] = in_data[31:0];
  assign in_cloud[1] = in_data[63:32];
  assign in_grid[0]  = in_data[95:64];
  assign in_grid[1]  = in_data[127:96];

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      // exact distance and its magnitude
      diff_c[a] = {in_grid[a][31], in_grid[a]} - {in_cloud[a][31], in_cloud[a]};
      mag_c[a]  = diff_c[a][32] ? (33'd0 - diff_c[a]) : diff_c[a];
      // scaled distance, 32 fraction bits
      r_c[a] = 64'(ad_q[a]) * 64'(inv_spacing[a]);
      // fold the far branch onto [0,1]
      near_c[a]   = (r_q[a] <= ONE_Q32);
      inside_c[a] = (r_q[a] <= TWO_Q32);
      u_c[a]      = near_c[a] ? r_q[a][32:0] : 33'(r_q[a] - ONE_Q32);
      ub_c[a]     = ONE_Q32_N - u_c[a];
      // 1 + 4u(1-u) with 62 fraction bits; ends of the range give a zero product
      arg_c[a] = ARG_BASE + 64'(ua_q[a]) * 64'(ub_q[a]);
      // numerator 3 - 2u +- sqrt, then divide by 8 with rounding
      sq_c[a] = {rl[ROOT_W][a].root, 1'b0};
      if (rl[ROOT_W][a].near) begin
        num_c[a] = THREE_Q32 - {2'b0, rl[ROOT_W][a].u, 1'b0} + {3'b0, sq_c[a]};
      end else begin
        num_c[a] = THREE_Q32 - {2'b0, rl[ROOT_W][a].u, 1'b0} - {3'b0, sq_c[a]};
      end
      rnd_c[a] = num_c[a] + PHI_ROUND;
      phi_c[a] = rl[ROOT_W][a].in_range ? rnd_c[a][34:3] : 32'd0;
      // axis factor, 48 fraction bits
      fac_c[a] = 63'(phi_q[a]) * 63'(inv_spacing[a]);
    end
  end

  // partial products of the two axis factors and their sum
  logic [63:0]  p00_c;
  logic [62:0]  p01_c, p10_c;
  logic [61:0]  p11_c;
  logic [63:0]  mid_c;
  logic [127:0] sum_c;
  logic [47:0]  round_c;
  logic [46:0]  wfull_c;

  always_comb begin
    p00_c   = 64'(fac_q[0][31:0])  * 64'(fac_q[1][31:0]);
    p01_c   = 63'(fac_q[0][31:0])  * 63'(fac_q[1][62:32]);
    p10_c   = 63'(fac_q[0][62:32]) * 63'(fac_q[1][31:0]);
    p11_c   = 62'(fac_q[0][62:32]) * 62'(fac_q[1][62:32]);
    mid_c   = 64'(p01_q) + 64'(p10_q);
    sum_c   = {2'b0, p11_m, p00_m} + {32'd0, mid_q, 32'd0};
    // round half up to 16 fraction bits, then saturate
    round_c = sum_hi_q + 48'd1;
    wfull_c = round_c[47:1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < AXES; a++) begin
        ad_q[a]           <= mag_c[a];
        r_q[a]            <= r_c[a];
        u_q[a]            <= u_c[a];
        ua_q[a]           <= u_c[a][31:0];
        ub_q[a]           <= ub_c[a][31:0];
        near_q[a]         <= near_c[a];
        inside_q[a]       <= inside_c[a];
        rl[0][a].rem      <= arg_c[a];
        rl[0][a].root     <= '0;
        rl[0][a].u        <= u_q[a];
        rl[0][a].near     <= near_q[a];
        rl[0][a].in_range <= inside_q[a];
        phi_q[a]          <= phi_c[a];
        fac_q[a]          <= fac_c[a];
      end
      sup_phi  <= rl[ROOT_W][0].in_range && rl[ROOT_W][1].in_range;
      sup_fact <= sup_phi;
      p00_q    <= p00_c;
      p01_q    <= p01_c;
      p10_q    <= p10_c;
      p11_q    <= p11_c;
      sup_part <= sup_fact;
      p00_m    <= p00_q;
      p11_m    <= p11_q;
      mid_q    <= mid_c;
      sup_mid  <= sup_part;
      sum_hi_q <= sum_c[126:79];
      sup_sum  <= sup_mid;
      weight_q <= (|wfull_c[46:36]) ? WEIGHT_MAX : wfull_c[35:0];
      sup_out  <= sup_sum;
    end
  end

  // square-root pipeline: one root bit per stage, most significant first
  for (genvar j = 0; j < ROOT_W; j++) begin : g_root
    localparam int B = ROOT_W - 1 - j;
    for (genvar a = 0; a < AXES; a++) begin : g_axis
      logic [63:0] delta;
      logic        take;

      assign delta = ({32'd0, rl[j][a].root} << (B + 1)) | (64'd1 << (2 * B));
      assign take  = (rl[j][a].rem >= delta);

      always_ff @(posedge clk) begin
        if (en) begin
          rl[j+1][a].rem      <= take ? (rl[j][a].rem - delta) : rl[j][a].rem;
          rl[j+1][a].root     <= take ? (rl[j][a].root | (32'd1 << B)) : rl[j][a].root;
          rl[j+1][a].u        <= rl[j][a].u;
          rl[j+1][a].near     <= rl[j][a].near;
          rl[j+1][a].in_range <= rl[j][a].in_range;
        end
      end
    end
  end

  assign m_tvalid = vld[ST_OUT];
  assign m_tdata  = {4'd0, weight_q};
  assign m_tuser  = sup_out;

  // a point outside the support always weighs zero
  a_zero_outside: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (weight_q == '0))
    else $error("nonzero weight outside support");

  // a transfer taken during an output stall lands in the skid register
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && m_tvalid && !m_tready) |=> !s_tready)
    else $error("skid register not holding a stalled transfer");

  // the root of an in-support argument lies in [2^31, 2^31.5)
  a_root_top: assert property (@(posedge clk) disable iff (rst)
    vld[ST_PHI-1] |->
      ((!rl[ROOT_W][0].in_range || rl[ROOT_W][0].root[ROOT_W-1]) &&
       (!rl[ROOT_W][1].in_range || rl[ROOT_W][1].root[ROOT_W-1])))
    else $error("square root out of range");

  // phi never exceeds one half
  a_phi_bound: assert property (@(posedge clk) disable iff (rst)
    vld[ST_PHI] |-> ((phi_q[0] <= PHI_MAX) && (phi_q[1] <= PHI_MAX)))
    else $error("kernel value above one half");

endmodule
